@@ rtl/mmc_pkg.sv @@
package mmc_pkg;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   localparam logic [1:0] REG_STATUS  = 2'd0;
   localparam logic [1:0] REG_CONTROL = 2'd1;
   localparam logic [1:0] REG_DATA    = 2'd2;
   localparam logic [1:0] REG_ADDRESS = 2'd3;

   localparam logic [1:0] START_C22 = 2'b01;
   localparam logic [1:0] START_C45 = 2'b00;

   localparam logic [1:0] OP_C45_ADDRESS  = 2'b00;
   localparam logic [1:0] OP_WRITE        = 2'b01;
   localparam logic [1:0] OP_C22_READ     = 2'b10;
   localparam logic [1:0] OP_C45_READ     = 2'b11;
   localparam logic [1:0] OP_C45_READ_INC = 2'b10;

   localparam logic [1:0] TA_DRIVEN   = 2'b10;
   localparam logic [1:0] TA_RELEASED = 2'b00;

   localparam int STATUS_BUSY_BIT    = 0;
   localparam int STATUS_ERROR_BIT   = 1;
   localparam int STATUS_C45_BIT     = 6;
   localparam int STATUS_DIVIDER_LSB = 8;
   localparam int CONTROL_PORT_LSB   = 5;
   localparam int CONTROL_PRE_BIT    = 10;
   localparam int CONTROL_INC_BIT    = 14;
   localparam int CONTROL_READ_BIT   = 15;
   localparam int DATA_BUSY_BIT      = 31;

   localparam logic [6:0] FRAME_BODY_BITS = 7'd32;
   localparam logic [6:0] TA_SAMPLE_COUNT = 7'd17;
   localparam logic [6:0] RELEASE_COUNT   = 7'd18;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  reg_select;
      logic [31:0] write_data;
      logic        mdio_in;
   } mmc_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        mdc;
      logic        mdio_out;
      logic        mdio_drive;
   } mmc_rsp_type;

endpackage

@@ rtl/mmc_input_stage.sv @@
module mmc_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mmc_pkg::mmc_req_type req_data,
   input  logic                 advance,
   output logic                 item_valid,
   output mmc_pkg::mmc_req_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   logic                 take;
   mmc_pkg::mmc_req_type item_ff;

   assign take      = !valid_ff || advance;
   assign req_stall = !take;

   always_comb begin
      if (req_valid && take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && take) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/mmc_engine.sv @@
module mmc_engine #(
   parameter int DIVIDER_BITS    = 8,
   parameter int PREAMBLE_LENGTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  mmc_pkg::mmc_req_type item,
   output mmc_pkg::mmc_rsp_type result
);

   localparam int               ShiftPre = 32 - PREAMBLE_LENGTH;
   localparam logic [31:0]      PreMask  = 32'((64'd1 << PREAMBLE_LENGTH) - 64'd1);
   localparam logic [6:0]       PreCount = 7'(PREAMBLE_LENGTH);

   logic                    clause45_ff, clause45_in;
   logic [DIVIDER_BITS-1:0] divider_ff, divider_in;
   logic [4:0]              port_ff, port_in;
   logic [4:0]              device_ff, device_in;
   logic                    pre_off_ff, pre_off_in;
   logic                    post_inc_ff, post_inc_in;
   logic [15:0]             data_ff, data_in;
   logic [15:0]             raddr_ff, raddr_in;
   logic                    busy_ff, busy_in;
   logic                    error_ff, error_in;
   logic [63:0]             shift_ff, shift_in;
   logic [6:0]              count_ff, count_in;
   logic                    is_read_ff, is_read_in;
   logic                    level_ff, level_in;
   logic [DIVIDER_BITS-1:0] div_count_ff, div_count_in;

   function automatic logic [63:0] frame_load(
      input logic [1:0]  st,
      input logic [1:0]  op,
      input logic        rd,
      input logic [4:0]  port,
      input logic [4:0]  dev,
      input logic [15:0] payload,
      input logic        pre_off
   );
      logic [31:0] body;
      logic [63:0] full;
      body = {st, op, port, dev, rd ? mmc_pkg::TA_RELEASED : mmc_pkg::TA_DRIVEN, payload};
      full = {PreMask, body} << ShiftPre;
      if (pre_off) begin
         full = {body, 32'd0};
      end
      return full;
   endfunction

   always_comb begin
      logic        start;
      logic [1:0]  st;
      logic [1:0]  op;
      logic        rd;
      logic [15:0] payload;
      logic [31:0] rdata;
      logic        drive;

      clause45_in  = clause45_ff;
      divider_in   = divider_ff;
      port_in      = port_ff;
      device_in    = device_ff;
      pre_off_in   = pre_off_ff;
      post_inc_in  = post_inc_ff;
      data_in      = data_ff;
      raddr_in     = raddr_ff;
      busy_in      = busy_ff;
      error_in     = error_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      is_read_in   = is_read_ff;
      level_in     = level_ff;
      div_count_in = div_count_ff;
      start        = 1'b0;
      st           = mmc_pkg::START_C22;
      op           = mmc_pkg::OP_WRITE;
      rd           = 1'b0;
      payload      = 16'd0;
      rdata        = 32'd0;

      case (item.mode)
         mmc_pkg::MODE_TICK: begin
            if (busy_ff) begin
               if (div_count_ff < divider_ff) begin
                  div_count_in = div_count_ff + 1'b1;
               end else begin
                  div_count_in = '0;
                  if (!level_ff) begin
                     level_in = 1'b1;
                     if (is_read_ff) begin
                        if (count_ff == mmc_pkg::TA_SAMPLE_COUNT && item.mdio_in) begin
                           error_in = 1'b1;
                        end else if (count_ff inside {[7'd1:7'd16]}) begin
                           data_in = {data_ff[14:0], item.mdio_in};
                        end
                     end
                  end else begin
                     level_in = 1'b0;
                     shift_in = {shift_ff[62:0], 1'b0};
                     if (count_ff != 7'd0) begin
                        count_in = count_ff - 7'd1;
                     end
                     if (count_in == 7'd0) begin
                        busy_in = 1'b0;
                        if (is_read_ff && clause45_ff && post_inc_ff) begin
                           raddr_in = raddr_ff + 16'd1;
                        end
                        is_read_in = 1'b0;
                     end
                  end
               end
            end
         end
         mmc_pkg::MODE_READ: begin
            case (item.reg_select)
               mmc_pkg::REG_STATUS: begin
                  rdata = (32'(divider_ff) << mmc_pkg::STATUS_DIVIDER_LSB)
                        | (32'(clause45_ff) << mmc_pkg::STATUS_C45_BIT)
                        | (32'(error_ff) << mmc_pkg::STATUS_ERROR_BIT)
                        | (32'(busy_ff) << mmc_pkg::STATUS_BUSY_BIT);
               end
               mmc_pkg::REG_CONTROL: begin
                  rdata = 32'(device_ff)
                        | (32'(port_ff) << mmc_pkg::CONTROL_PORT_LSB)
                        | (32'(pre_off_ff) << mmc_pkg::CONTROL_PRE_BIT)
                        | (32'(post_inc_ff) << mmc_pkg::CONTROL_INC_BIT);
               end
               mmc_pkg::REG_DATA: begin
                  rdata = 32'(data_ff) | (32'(busy_ff) << mmc_pkg::DATA_BUSY_BIT);
               end
               default: begin
                  rdata = 32'(raddr_ff);
               end
            endcase
         end
         mmc_pkg::MODE_WRITE: begin
            if (item.reg_select == mmc_pkg::REG_STATUS) begin
               clause45_in = item.write_data[mmc_pkg::STATUS_C45_BIT];
               divider_in  = item.write_data[mmc_pkg::STATUS_DIVIDER_LSB +: DIVIDER_BITS];
            end else if (!busy_ff) begin
               case (item.reg_select)
                  mmc_pkg::REG_CONTROL: begin
                     device_in   = item.write_data[4:0];
                     port_in     = item.write_data[mmc_pkg::CONTROL_PORT_LSB +: 5];
                     pre_off_in  = item.write_data[mmc_pkg::CONTROL_PRE_BIT];
                     post_inc_in = item.write_data[mmc_pkg::CONTROL_INC_BIT];
                     if (item.write_data[mmc_pkg::CONTROL_READ_BIT]) begin
                        start = 1'b1;
                        rd    = 1'b1;
                        if (clause45_ff) begin
                           st = mmc_pkg::START_C45;
                           op = post_inc_in ? mmc_pkg::OP_C45_READ_INC
                                            : mmc_pkg::OP_C45_READ;
                        end else begin
                           st = mmc_pkg::START_C22;
                           op = mmc_pkg::OP_C22_READ;
                        end
                     end
                  end
                  mmc_pkg::REG_DATA: begin
                     data_in = item.write_data[15:0];
                     start   = 1'b1;
                     st      = clause45_ff ? mmc_pkg::START_C45 : mmc_pkg::START_C22;
                     op      = mmc_pkg::OP_WRITE;
                     payload = item.write_data[15:0];
                  end
                  default: begin
                     raddr_in = item.write_data[15:0];
                     if (clause45_ff) begin
                        start   = 1'b1;
                        st      = mmc_pkg::START_C45;
                        op      = mmc_pkg::OP_C45_ADDRESS;
                        payload = item.write_data[15:0];
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      if (start) begin
         shift_in     = frame_load(st, op, rd, port_in, device_in, payload, pre_off_in);
         count_in     = (pre_off_in ? 7'd0 : PreCount) + mmc_pkg::FRAME_BODY_BITS;
         is_read_in   = rd;
         busy_in      = 1'b1;
         level_in     = 1'b0;
         div_count_in = '0;
         if (rd) begin
            error_in = 1'b0;
         end
      end

      drive = busy_in && !(is_read_in && count_in <= mmc_pkg::RELEASE_COUNT);
      result.read_data  = rdata;
      result.mdc        = level_in;
      result.mdio_out   = drive && shift_in[63];
      result.mdio_drive = drive;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clause45_ff  <= 1'b0;
         divider_ff   <= '0;
         port_ff      <= 5'd0;
         device_ff    <= 5'd0;
         pre_off_ff   <= 1'b0;
         post_inc_ff  <= 1'b0;
         data_ff      <= 16'd0;
         raddr_ff     <= 16'd0;
         busy_ff      <= 1'b0;
         error_ff     <= 1'b0;
         shift_ff     <= 64'd0;
         count_ff     <= 7'd0;
         is_read_ff   <= 1'b0;
         level_ff     <= 1'b0;
         div_count_ff <= '0;
      end else if (fire) begin
         clause45_ff  <= clause45_in;
         divider_ff   <= divider_in;
         port_ff      <= port_in;
         device_ff    <= device_in;
         pre_off_ff   <= pre_off_in;
         post_inc_ff  <= post_inc_in;
         data_ff      <= data_in;
         raddr_ff     <= raddr_in;
         busy_ff      <= busy_in;
         error_ff     <= error_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         is_read_ff   <= is_read_in;
         level_ff     <= level_in;
         div_count_ff <= div_count_in;
      end
   end

`ifndef SYNTHESIS
   busy_matches_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (count_ff != 7'd0))
      else $error("Busy flag and remaining bit count disagree.");

   clock_high_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      level_ff |-> busy_ff)
      else $error("Management clock is high outside a frame.");

   idle_tick_holds_frame: assert property (@(posedge clock) disable iff (reset)
      fire && item.mode == mmc_pkg::MODE_TICK && !busy_ff
      |=> $stable(shift_ff) && $stable(level_ff) && $stable(data_ff))
      else $error("An idle tick changed the frame state.");
`endif

endmodule

@@ rtl/mmc_output_stage.sv @@
module mmc_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mmc_pkg::mmc_rsp_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mmc_pkg::mmc_rsp_type rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   mmc_pkg::mmc_rsp_type data_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ rtl/mdio_master_controller_unit.sv @@
// MDIO management master for clause 22 and clause 45 devices behind four registers (status,
// control, data, address). Every item is a system clock tick, a register read or a register
// write, and one item is taken in every cycle unless the input register is full and the
// output is stalled; its result passes from the input register through the register-update
// stage to the result register. Each result carries the pin levels after that item. MDC
// toggles once every clock divider plus one tick items while a frame is in progress.
module mdio_master_controller_unit #(
   parameter int DIVIDER_BITS    = 8,
   parameter int PREAMBLE_LENGTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mmc_pkg::mmc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mmc_pkg::mmc_rsp_type rsp_data
);

   logic                 item_valid;
   logic                 out_free;
   logic                 advance;
   mmc_pkg::mmc_req_type item;
   mmc_pkg::mmc_rsp_type result;

   assign advance = item_valid && out_free;

   mmc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mmc_engine #(
      .DIVIDER_BITS    (DIVIDER_BITS),
      .PREAMBLE_LENGTH (PREAMBLE_LENGTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   mmc_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
